// ===== rtl/core/dsr_pkg.sv =====
// ----------------------------------------------------------------------------
// dsr_pkg: shared definitions of the decimal string rounder
// character codes, rounding modes, field widths and default sizes
// ----------------------------------------------------------------------------
package dsr_pkg;

    localparam int CHAR_W = 8;
    localparam int MODE_W = 2;
    localparam int CFG_W  = 5;

    localparam int MAX_DIGITS_DEF = 32;
    localparam int MAX_FRAC_DEF   = 16;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [3:0]        t_digit;

    localparam logic [CFG_W-1:0] FRAC_RESET = 5'd2;

    // rounding modes, a zero code behaves as truncate
    localparam t_mode MODE_HALF_UP   = 2'd1;
    localparam t_mode MODE_TRUNC     = 2'd2;
    localparam t_mode MODE_HALF_EVEN = 2'd3;

    localparam t_char CH_MINUS = 8'h2D;
    localparam t_char CH_POINT = 8'h2E;
    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_ONE   = 8'h31;
    localparam t_char CH_NINE  = 8'h39;

    localparam t_digit DIGIT_HALF = 4'd5;
    localparam t_digit DIGIT_NINE = 4'd9;

endpackage

// ===== rtl/core/dsr_in_if.sv =====
// ----------------------------------------------------------------------------
// dsr_in_if: character request channel into the rounder
// valid/ready handshake carrying one input character with mode and end mark
// ----------------------------------------------------------------------------
interface dsr_in_if;
    import dsr_pkg::*;

    logic  valid;
    logic  ready;
    t_char ch;
    t_mode mode;
    logic  last_char;

    modport source (output valid, output ch, output mode, output last_char, input ready);
    modport sink   (input valid, input ch, input mode, input last_char, output ready);

endinterface

// ===== rtl/core/dsr_out_if.sv =====
// ----------------------------------------------------------------------------
// dsr_out_if: result channel out of the rounder
// valid/ready handshake carrying one rounded character per request
// ----------------------------------------------------------------------------
interface dsr_out_if;
    import dsr_pkg::*;

    logic  valid;
    logic  ready;
    t_char out_char;
    logic  too_long;
    logic  last_out;

    modport source (output valid, output out_char, output too_long, output last_out,
                    input ready);
    modport sink   (input valid, input out_char, input too_long, input last_out,
                    output ready);

endinterface

// ===== rtl/core/decimal_string_rounder.sv =====
// ----------------------------------------------------------------------------
// decimal_string_rounder: rounds a signed decimal ascii string
// stores the digits of one number, rounds it to frac_digits places and
// sends the rounded string back one character per request
// ----------------------------------------------------------------------------
// usage
//   i_in carries one character per request; last_char closes a number and its
//   mode field picks half-up, truncate or half-even rounding
//   o_out returns '-' if nonzero, a leading carry '1', integer digits, '.'
//   and frac_digits fraction digits; last_out marks the final character
//   i_cfg_we / i_cfg_data set frac_digits (reset value 2) between numbers
// timing
//   characters are taken one per cycle; after the closing character i_in is
//   held off while one shared digit-store read port does all the work:
//   a statistics pass over the I integer and F stored fraction digits,
//   a decision step, a carry search back over the N kept digits, then
//   the sign and carry slots, the point and each digit in turn,
//   followed by a final step that clears the number
// reset and stall
//   synchronous active-low reset empties the number, drops any pending
//   result and restores frac_digits; o_out is registered so a stalled
//   receiver simply freezes the emission sequence, nothing is lost
// ----------------------------------------------------------------------------
module decimal_string_rounder #(
    parameter int MAX_DIGITS = dsr_pkg::MAX_DIGITS_DEF,
    parameter int MAX_FRAC   = dsr_pkg::MAX_FRAC_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    dsr_in_if.sink                    i_in,
    dsr_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [dsr_pkg::CFG_W-1:0] i_cfg_data
);
    import dsr_pkg::*;

    // digit store: integer digits first, then fraction digits plus guard
    localparam int DEPTH = MAX_DIGITS + MAX_FRAC + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(DEPTH + 1);
    localparam int NW    = $clog2(MAX_DIGITS + 1);
    localparam int FW    = $clog2(MAX_FRAC + 2);

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_PRE_RD   = 4'd1;
    localparam logic [3:0] S_PRE_CHK  = 4'd2;
    localparam logic [3:0] S_DEC      = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CHK = 4'd5;
    localparam logic [3:0] S_SIGN     = 4'd6;
    localparam logic [3:0] S_ONE      = 4'd7;
    localparam logic [3:0] S_POS      = 4'd8;
    localparam logic [3:0] S_DIG      = 4'd9;

    logic [3:0]       r_state;
    logic [CFG_W-1:0] r_frac;
    t_digit           r_mem [DEPTH];
    t_digit           r_rd_data;

    // per-number state
    logic [NW-1:0]    r_ni;
    logic [FW-1:0]    r_fc;
    logic             r_neg;
    logic             r_seen;
    logic             r_sticky;
    logic             r_ovf;
    t_mode            r_mode;

    // rounding decision
    t_digit           r_guard;
    logic             r_par;
    logic             r_nz;
    logic             r_inc;
    logic             r_cout;
    logic             r_pt_done;
    logic [KW-1:0]    r_k;
    logic [KW-1:0]    r_q;

    // output register
    logic             r_out_vld;
    t_char            r_out_char;
    logic             r_out_last;
    logic             r_out_long;

    logic [FW-1:0]    frac_keep;
    logic [KW-1:0]    ni_k;
    logic [KW-1:0]    kept_len;
    logic [KW-1:0]    stored_len;
    logic [KW-1:0]    k_off;
    logic             k_in_int;
    logic             k_present;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic             wr_en;
    t_char            ch_off;
    t_digit           in_val;
    t_digit           rd_val;
    t_digit           out_val;
    logic             accept;
    logic             is_digit;
    logic             slot_free;
    logic             nonzero;
    logic             dec_inc;
    logic             put;
    t_char            put_char;
    logic             put_last;

    assign accept    = i_in.valid && i_in.ready;
    assign slot_free = !r_out_vld || o_out.ready;

    // frac_digits above the fraction storage saturates
    assign frac_keep  = (r_frac > CFG_W'(MAX_FRAC)) ? FW'(MAX_FRAC) : FW'(r_frac);
    assign ni_k       = KW'(r_ni);
    assign kept_len   = ni_k + KW'(frac_keep);
    assign stored_len = ni_k + KW'(r_fc);

    // map a digit position of the whole number onto the store
    assign k_off     = r_k - ni_k;
    assign k_in_int  = r_k < ni_k;
    assign k_present = k_in_int || (k_off < KW'(r_fc));
    assign rd_addr   = k_in_int ? AW'(r_k) : AW'(MAX_DIGITS) + AW'(k_off);

    // fraction digits that were never given read as zero
    assign rd_val  = k_present ? r_rd_data : '0;
    assign nonzero = r_nz || r_inc;

    // load side
    assign ch_off   = i_in.ch - CH_ZERO;
    assign in_val   = ch_off[3:0];
    assign is_digit = (i_in.ch >= CH_ZERO) && (i_in.ch <= CH_NINE);
    assign wr_en    = accept && is_digit &&
                      (r_seen ? (r_fc < FW'(MAX_FRAC + 1)) : (r_ni < NW'(MAX_DIGITS)));
    assign wr_addr  = r_seen ? AW'(MAX_DIGITS) + AW'(r_fc) : AW'(r_ni);

    always_comb begin
        case (r_state)
            S_PRE_RD:  rd_en = (r_k != stored_len);
            S_SCAN_RD: rd_en = 1'b1;
            S_POS:     rd_en = !((r_k == ni_k) && !r_pt_done) && (r_k != kept_len);
            default:   rd_en = 1'b0;
        endcase
    end

    // round-up decision from guard digit, sticky bit and last kept digit
    always_comb begin
        case (r_mode)
            MODE_HALF_UP:   dec_inc = (r_guard >= DIGIT_HALF);
            MODE_HALF_EVEN: dec_inc = (r_guard > DIGIT_HALF) ||
                                      ((r_guard == DIGIT_HALF) && (r_sticky || r_par));
            default:        dec_inc = 1'b0;
        endcase
    end

    // incremented digit value: trailing nines past the carry stop become zero
    always_comb begin
        if (r_cout) begin
            out_val = '0;
        end else if (r_inc && (r_k > r_q)) begin
            out_val = '0;
        end else if (r_inc && (r_k == r_q)) begin
            out_val = rd_val + 4'd1;
        end else begin
            out_val = rd_val;
        end
    end

    // character to send in the current emission step
    always_comb begin
        put      = 1'b0;
        put_char = CH_POINT;
        put_last = 1'b0;
        case (r_state)
            S_SIGN: begin
                put      = r_neg && nonzero;
                put_char = CH_MINUS;
            end
            S_ONE: begin
                put      = r_cout;
                put_char = CH_ONE;
            end
            S_POS: begin
                put      = (r_k == ni_k) && !r_pt_done;
                put_char = CH_POINT;
                put_last = (frac_keep == '0);
            end
            S_DIG: begin
                put      = 1'b1;
                put_char = CH_ZERO + CHAR_W'(out_val);
                put_last = r_pt_done && ((r_k + KW'(1)) == kept_len);
            end
            default: begin
                put = 1'b0;
            end
        endcase
    end

    // digit store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= in_val;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (put && slot_free) begin
            r_out_char <= put_char;
            r_out_last <= put_last;
            r_out_long <= r_ovf;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_frac    <= FRAC_RESET;
            r_ni      <= '0;
            r_fc      <= '0;
            r_neg     <= 1'b0;
            r_seen    <= 1'b0;
            r_sticky  <= 1'b0;
            r_ovf     <= 1'b0;
            r_mode    <= MODE_TRUNC;
            r_guard   <= '0;
            r_par     <= 1'b0;
            r_nz      <= 1'b0;
            r_inc     <= 1'b0;
            r_cout    <= 1'b0;
            r_pt_done <= 1'b0;
            r_k       <= '0;
            r_q       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frac <= i_cfg_data;
            end

            if (put && slot_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (i_in.ch == CH_MINUS) begin
                            // a minus counts only ahead of any digit or point
                            if ((r_ni == '0) && !r_seen && !r_ovf) begin
                                r_neg <= 1'b1;
                            end
                        end else if (i_in.ch == CH_POINT) begin
                            r_seen <= 1'b1;
                        end else if (is_digit) begin
                            if (r_seen) begin
                                if (r_fc < FW'(MAX_FRAC + 1)) begin
                                    r_fc <= r_fc + FW'(1);
                                end else if (in_val != '0) begin
                                    r_sticky <= 1'b1;
                                end
                            end else begin
                                if (r_ni < NW'(MAX_DIGITS)) begin
                                    r_ni <= r_ni + NW'(1);
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                        end
                        if (i_in.last_char) begin
                            r_mode  <= i_in.mode;
                            r_k     <= '0;
                            r_guard <= '0;
                            r_par   <= 1'b0;
                            r_nz    <= 1'b0;
                            r_state <= S_PRE_RD;
                        end
                    end
                end

                S_PRE_RD: begin
                    r_state <= (r_k == stored_len) ? S_DEC : S_PRE_CHK;
                end

                // kept digits, last kept digit, guard digit and sticky tail
                S_PRE_CHK: begin
                    if ((r_k < kept_len) && (r_rd_data != '0)) begin
                        r_nz <= 1'b1;
                    end
                    if ((r_k + KW'(1)) == kept_len) begin
                        r_par <= r_rd_data[0];
                    end
                    if (r_k == kept_len) begin
                        r_guard <= r_rd_data;
                    end
                    if ((r_k > kept_len) && (r_rd_data != '0)) begin
                        r_sticky <= 1'b1;
                    end
                    r_k     <= r_k + KW'(1);
                    r_state <= S_PRE_RD;
                end

                S_DEC: begin
                    r_inc     <= dec_inc;
                    r_cout    <= 1'b0;
                    r_pt_done <= 1'b0;
                    if (dec_inc && (kept_len != '0)) begin
                        r_k     <= kept_len - KW'(1);
                        r_state <= S_SCAN_RD;
                    end else begin
                        r_cout  <= dec_inc;
                        r_state <= S_SIGN;
                    end
                end

                S_SCAN_RD: begin
                    r_state <= S_SCAN_CHK;
                end

                // walk back to the first digit that absorbs the carry
                S_SCAN_CHK: begin
                    if (rd_val != DIGIT_NINE) begin
                        r_q     <= r_k;
                        r_state <= S_SIGN;
                    end else if (r_k == '0) begin
                        r_cout  <= 1'b1;
                        r_state <= S_SIGN;
                    end else begin
                        r_k     <= r_k - KW'(1);
                        r_state <= S_SCAN_RD;
                    end
                end

                S_SIGN: begin
                    if (!put || slot_free) begin
                        r_state <= S_ONE;
                    end
                end

                S_ONE: begin
                    if (!put || slot_free) begin
                        r_k     <= '0;
                        r_state <= S_POS;
                    end
                end

                S_POS: begin
                    if (put) begin
                        if (slot_free) begin
                            r_pt_done <= 1'b1;
                        end
                    end else if (r_k == kept_len) begin
                        r_ni     <= '0;
                        r_fc     <= '0;
                        r_neg    <= 1'b0;
                        r_seen   <= 1'b0;
                        r_sticky <= 1'b0;
                        r_ovf    <= 1'b0;
                        r_state  <= S_LOAD;
                    end else begin
                        r_state <= S_DIG;
                    end
                end

                S_DIG: begin
                    if (slot_free) begin
                        r_k     <= r_k + KW'(1);
                        r_state <= S_POS;
                    end
                end

                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign i_in.ready     = (r_state == S_LOAD);
    assign o_out.valid    = r_out_vld;
    assign o_out.out_char = r_out_char;
    assign o_out.too_long = r_out_long;
    assign o_out.last_out = r_out_last;

endmodule
